/* src/opmq_pkg.sv */
// Shared types and constants for the ordered priority message queue.
`default_nettype none

package opmq_pkg;

  localparam int CMD_W  = 3;
  localparam int ID_W   = 32;
  localparam int PRIO_W = 8;
  localparam int OCC_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP_FIRST = 3'd1,
    CMD_POP_EXACT = 3'd2,
    CMD_POP_ABOVE = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [ID_W-1:0] id;
    logic [PRIO_W-1:0]      prio;
  } entry_t;

endpackage

`default_nettype wire

/* src/opmq_if.sv */
// Command and result channel interfaces of the ordered priority message queue.
`default_nettype none

interface opmq_req_if import opmq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic signed [ID_W-1:0] msg_id;
  logic [PRIO_W-1:0]      prio;

  modport source (output valid, cmd, msg_id, prio, input ready);
  modport sink   (input valid, cmd, msg_id, prio, output ready);
endinterface

interface opmq_rsp_if import opmq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic signed [ID_W-1:0] out_id;
  logic [PRIO_W-1:0]      out_prio;
  logic [OCC_W-1:0]       occupancy;
  logic                   is_empty;

  modport source (output valid, ok, out_id, out_prio, occupancy, is_empty, input ready);
  modport sink   (input valid, ok, out_id, out_prio, occupancy, is_empty, output ready);
endinterface

`default_nettype wire

/* src/opmq_store.sv */
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module opmq_store import opmq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                        rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire entry_t                   wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/opmq_ctrl.sv */
// Command sequencer: walks the entry memory to insert or remove one entry; clear empties the queue without a walk.
`default_nettype none

module opmq_ctrl import opmq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  opmq_req_if.sink                         req,
  opmq_rsp_if.source                       rsp,
  output logic                             rd_en,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr,
  input  wire entry_t                      rd_data,
  output logic                             wr_en,
  output logic [$clog2(CAPACITY)-1:0]      wr_addr,
  output entry_t                           wr_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t              state, state_next;
  logic [CMD_W-1:0]    op;
  logic [PRIO_W-1:0]   key;
  logic signed [ID_W-1:0] new_id;
  logic [CW-1:0]       count;
  logic [CW-1:0]       iss;
  logic                iss_live;
  logic [CW-1:0]       prc;
  logic                prc_vld;
  logic                found;
  entry_t              res;
  entry_t              prev;

  logic                rsp_valid;
  logic                rsp_ok;
  entry_t              rsp_entry;
  logic [OCC_W-1:0]    rsp_occ;
  logic                rsp_empty;

  logic                accept;
  logic                walking;
  logic                issue;
  logic                iss_last;
  logic                rsp_load;
  logic [CW-1:0]       iss_m1;
  logic [CW-1:0]       prc_m1;
  logic                fin;
  logic                take_elem;
  logic                take_prev;
  logic                cnt_inc;
  logic                cnt_dec;

  assign accept   = req.valid && req.ready;
  assign walking  = (state == ST_FWD) || (state == ST_BWD);
  assign iss_last = (state == ST_BWD) ? (iss == '0) : (iss == count);
  assign issue    = walking && iss_live;
  assign iss_m1   = iss - CW'(1);
  assign prc_m1   = prc - CW'(1);
  assign rsp_load = (state == ST_DONE) && (!rsp_valid || rsp.ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.cmd) inside
            CMD_PUSH:
              state_next = (count == CW'(CAPACITY)) ? ST_DONE : ST_BWD;
            CMD_POP_FIRST, CMD_POP_EXACT, CMD_POP_ABOVE:
              state_next = (count == '0) ? ST_DONE : ST_FWD;
            default:
              state_next = ST_DONE;
          endcase
        end
      end
      ST_FWD, ST_BWD: begin
        if (fin) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.ok        = rsp_ok;
  assign rsp.out_id    = rsp_entry.id;
  assign rsp.out_prio  = rsp_entry.prio;
  assign rsp.occupancy = rsp_occ;
  assign rsp.is_empty  = rsp_empty;

  // Walk decisions and memory accesses
  always_comb begin
    fin       = 1'b0;
    take_elem = 1'b0;
    take_prev = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = prc_m1[AW-1:0];
    wr_data   = rd_data;
    rd_en     = 1'b0;
    rd_addr   = iss[AW-1:0];

    if (state == ST_FWD) begin
      rd_en   = issue && (iss != count);
      rd_addr = iss[AW-1:0];
      if (prc_vld) begin
        if (prc == count) begin
          // past the last entry: pop above takes the tail if all exceed the bound
          fin       = 1'b1;
          take_prev = !found && (op == CMD_POP_ABOVE);
          cnt_dec   = found || take_prev;
        end else if (found) begin
          wr_en = 1'b1;
        end else begin
          case (op)
            CMD_POP_FIRST: take_elem = 1'b1;
            CMD_POP_EXACT: take_elem = (rd_data.prio == key);
            CMD_POP_ABOVE: begin
              if (rd_data.prio <= key) begin
                if (prc == '0) begin
                  fin = 1'b1;
                end else begin
                  take_prev = 1'b1;
                  wr_en     = 1'b1;
                end
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
    end else if (state == ST_BWD) begin
      rd_en   = issue && (iss != '0);
      rd_addr = iss_m1[AW-1:0];
      wr_addr = prc[AW-1:0];
      if (prc_vld) begin
        wr_en = 1'b1;
        if ((prc == '0) || (rd_data.prio >= key)) begin
          // slot found: drop the new entry here
          wr_data = '{id: new_id, prio: key};
          fin     = 1'b1;
          cnt_inc = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      iss_live  <= 1'b0;
      prc_vld   <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        op       <= req.cmd;
        key      <= req.prio;
        new_id   <= req.msg_id;
        found    <= (req.cmd == CMD_CLEAR);
        res      <= '0;
        prc_vld  <= 1'b0;
        iss_live <= 1'b1;
        iss      <= (req.cmd == CMD_PUSH) ? count : '0;
        if (req.cmd == CMD_CLEAR) count <= '0;
      end else if (walking) begin
        if (issue) begin
          iss      <= (state == ST_BWD) ? iss_m1 : iss + CW'(1);
          iss_live <= !iss_last;
        end
        prc_vld <= issue;
        prc     <= iss;
        if (take_elem) begin
          found <= 1'b1;
          res   <= rd_data;
        end
        if (take_prev) begin
          found <= 1'b1;
          res   <= prev;
        end
        if (cnt_inc) found <= 1'b1;
        if ((state == ST_FWD) && prc_vld) prev <= rd_data;
        if (cnt_dec) count <= count - CW'(1);
        if (cnt_inc) count <= count + CW'(1);
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_ok    <= found;
      rsp_entry <= res;
      rsp_occ   <= OCC_W'(count);
      rsp_empty <= (count == '0);
    end
  end

endmodule

`default_nettype wire

/* src/ordered_priority_message_queue_top.sv */
// Results: clear, unknown codes, push when full and pops on an empty queue go straight
// to the done state; other commands first walk the entry memory, at most one pass,
// through its single read port.
// Commands: the next command is taken in the cycle after the result is loaded, one at
// a time; a result side that stalls holds it back.
// Reset (synchronous): the queue empties and no result is pending; memory is kept.
`default_nettype none

module ordered_priority_message_queue_top import opmq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  opmq_req_if.sink   req,
  opmq_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  opmq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  opmq_store #(.DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

`default_nettype wire

/* src/opmq_checker.sv */
// Port-level checks of the ordered priority message queue, bound to the top level.
`default_nettype none

module opmq_checker import opmq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   req_valid,
  input wire logic                   req_ready,
  input wire logic                   rsp_valid,
  input wire logic                   rsp_ready,
  input wire logic                   rsp_ok,
  input wire logic signed [ID_W-1:0] rsp_out_id,
  input wire logic [PRIO_W-1:0]      rsp_out_prio,
  input wire logic [OCC_W-1:0]       rsp_occupancy,
  input wire logic                   rsp_is_empty
);

  // one command in the sequencer at a time
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while another was in progress");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> (rsp_out_id == '0) && (rsp_out_prio == '0))
    else $error("failed command returned an entry");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp_occupancy) <= 32'(CAPACITY)))
    else $error("occupancy beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occupancy))
    else $error("stalled transaction dropped or changed");

endmodule

bind ordered_priority_message_queue_top opmq_checker #(.CAPACITY(CAPACITY)) u_opmq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_ok        (rsp.ok),
  .rsp_out_id    (rsp.out_id),
  .rsp_out_prio  (rsp.out_prio),
  .rsp_occupancy (rsp.occupancy),
  .rsp_is_empty  (rsp.is_empty)
);

`default_nettype wire
